// ----- design/sdif_pkg.sv -----
`default_nettype none
package sdif_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SLOT_W      = 7;

   typedef enum logic [2:0] {
      ST_FOUND     = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4,
      ST_ZERO_KEY  = 3'd5
   } status_type;

   typedef enum logic {
      REQ_FIND = 1'b0,
      REQ_ADD  = 1'b1
   } req_kind_type;

   localparam logic CSR_COUNT_TYPE  = 1'b0;
   localparam logic CSR_COUNT_FLAGS = 1'b1;

   typedef struct packed {
      logic [15:0] index;
      logic [7:0]  sub;
      logic [7:0]  flags;
      logic [7:0]  etype;
      logic [31:0] data;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DECIDE,
      S_SH_RD,
      S_SH_WR,
      S_INS_WR,
      S_CNT,
      S_CNT_RD,
      S_CNT_WR,
      S_OUT_RD,
      S_OUT
   } fsm_state_type;

   typedef struct packed {
      logic       accept;
      logic       scan_rd;
      logic       scan_chk;
      logic       scan_end_set;
      logic       set_status;
      status_type status_code;
      logic       set_have;
      logic       upd_wr;
      logic       shift_start_main;
      logic       shift_start_cnt;
      logic       shift_rd;
      logic       shift_wr;
      logic       ins_wr;
      logic       cnt_rd;
      logic       cnt_wr;
      logic       out_rd;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic p_hit;
      logic req_find;
      logic zero_key;
      logic full;
      logic sub_zero;
      logic match;
      logic has_cnt;
      logic shift_done;
      logic phase_cnt;
      logic rsp_free;
   } dp_sts_type;

endpackage
`default_nettype wire

// ----- design/sdif_ctrl.sv -----
`default_nettype none
module sdif_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  sdif_pkg::dp_sts_type   sts,
   output sdif_pkg::dp_cmd_type   cmd
);

   sdif_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= sdif_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdif_pkg::S_IDLE:     if (req_tvalid) state_in = sdif_pkg::S_SCAN_RD;
         sdif_pkg::S_SCAN_RD:  state_in = sts.scan_end ? sdif_pkg::S_DECIDE : sdif_pkg::S_SCAN_CHK;
         sdif_pkg::S_SCAN_CHK: state_in = sts.p_hit ? sdif_pkg::S_DECIDE : sdif_pkg::S_SCAN_RD;
         sdif_pkg::S_DECIDE: begin
            if (sts.req_find)                  state_in = sts.match ? sdif_pkg::S_OUT_RD
                                                                    : sdif_pkg::S_OUT;
            else if (sts.zero_key || sts.full) state_in = sdif_pkg::S_OUT;
            else if (sts.match)                state_in = sdif_pkg::S_CNT;
            else                               state_in = sdif_pkg::S_SH_RD;
         end
         sdif_pkg::S_SH_RD:    state_in = sts.shift_done ? sdif_pkg::S_INS_WR : sdif_pkg::S_SH_WR;
         sdif_pkg::S_SH_WR:    state_in = sdif_pkg::S_SH_RD;
         sdif_pkg::S_INS_WR:   state_in = sts.phase_cnt ? sdif_pkg::S_OUT_RD : sdif_pkg::S_CNT;
         sdif_pkg::S_CNT: begin
            if (sts.sub_zero)     state_in = sdif_pkg::S_OUT_RD;
            else if (sts.has_cnt) state_in = sdif_pkg::S_CNT_RD;
            else                  state_in = sdif_pkg::S_SH_RD;
         end
         sdif_pkg::S_CNT_RD:   state_in = sdif_pkg::S_CNT_WR;
         sdif_pkg::S_CNT_WR:   state_in = sdif_pkg::S_OUT_RD;
         sdif_pkg::S_OUT_RD:   state_in = sdif_pkg::S_OUT;
         sdif_pkg::S_OUT:      if (sts.rsp_free) state_in = sdif_pkg::S_IDLE;
         default:              state_in = sdif_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status_code = sdif_pkg::ST_FOUND;
      req_tready = (state_ff == sdif_pkg::S_IDLE);
      case (state_ff)
         sdif_pkg::S_IDLE:     cmd.accept = req_tvalid;
         sdif_pkg::S_SCAN_RD: begin
            cmd.scan_end_set = sts.scan_end;
            cmd.scan_rd      = !sts.scan_end;
         end
         sdif_pkg::S_SCAN_CHK: cmd.scan_chk = 1'b1;
         sdif_pkg::S_DECIDE: begin
            cmd.set_status = 1'b1;
            if (sts.req_find) begin
               cmd.status_code = sts.match ? sdif_pkg::ST_FOUND : sdif_pkg::ST_NOT_FOUND;
               cmd.set_have    = sts.match;
            end else if (sts.zero_key) begin
               cmd.status_code = sdif_pkg::ST_ZERO_KEY;
            end else if (sts.full) begin
               cmd.status_code = sdif_pkg::ST_FULL;
            end else if (sts.match) begin
               cmd.status_code = sdif_pkg::ST_UPDATED;
               cmd.set_have    = 1'b1;
               cmd.upd_wr      = 1'b1;
            end else begin
               cmd.status_code      = sdif_pkg::ST_INSERTED;
               cmd.set_have         = 1'b1;
               cmd.shift_start_main = 1'b1;
            end
         end
         sdif_pkg::S_SH_RD:    cmd.shift_rd = !sts.shift_done;
         sdif_pkg::S_SH_WR:    cmd.shift_wr = 1'b1;
         sdif_pkg::S_INS_WR:   cmd.ins_wr = 1'b1;
         sdif_pkg::S_CNT:      cmd.shift_start_cnt = !sts.sub_zero && !sts.has_cnt;
         sdif_pkg::S_CNT_RD:   cmd.cnt_rd = 1'b1;
         sdif_pkg::S_CNT_WR:   cmd.cnt_wr = 1'b1;
         sdif_pkg::S_OUT_RD:   cmd.out_rd = 1'b1;
         sdif_pkg::S_OUT:      cmd.out_load = sts.rsp_free;
         default:              cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- design/sdif_dp.sv -----
`default_nettype none
module sdif_dp (
   input  wire                    clock,
   input  wire                    reset,
   input  sdif_pkg::dp_cmd_type   cmd,
   output sdif_pkg::dp_sts_type   sts,
   input  wire                    req_kind,
   input  sdif_pkg::entry_type    req_entry,
   input  wire                    csr_valid,
   input  wire                    csr_index,
   input  wire [7:0]              csr_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [2:0]             rsp_status,
   output logic [sdif_pkg::SLOT_W-1:0] rsp_slot,
   output logic [7:0]             rsp_flags,
   output logic [7:0]             rsp_type,
   output logic [31:0]            rsp_data
);

   localparam int AW = sdif_pkg::ADDR_W;
   localparam int CW = sdif_pkg::CNT_W;

   sdif_pkg::entry_type mem [sdif_pkg::TABLE_DEPTH];
   sdif_pkg::entry_type rd_q_ff, req_ff, wdata;
   logic                kind_ff;
   logic [CW-1:0]       i_ff, p_ff, c_ff, j_ff, pos_ff, count_ff;
   logic                pdone_ff, cdone_ff, match_ff, hascnt_ff, phase_ff, have_ff;
   logic [7:0]          cfg_type_ff, cfg_flags_ff;
   sdif_pkg::status_type status_ff;
   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [sdif_pkg::SLOT_W-1:0] rsp_slot_ff;
   logic [7:0]          rsp_flags_ff, rsp_type_ff;
   logic [31:0]         rsp_data_ff;

   logic [23:0]   dev_rd, tdev, cdev;
   logic          c_hit, p_hit, cnt_lower, we, re;
   logic [AW-1:0] waddr, raddr;
   logic [CW-1:0] j_dec;
   logic [CW:0]   need;
   logic [1:0]    extra;

   assign dev_rd    = {rd_q_ff.index, rd_q_ff.sub};
   assign tdev      = {req_ff.index, req_ff.sub};
   assign cdev      = {req_ff.index, 8'd0};
   assign c_hit     = !cdone_ff && (dev_rd >= cdev);
   assign p_hit     = !pdone_ff && (dev_rd >= tdev);
   assign cnt_lower = rd_q_ff.data < 32'(req_ff.sub);
   assign j_dec     = j_ff - CW'(1);
   assign extra     = 2'(!match_ff) + 2'((req_ff.sub != 8'd0) && !hascnt_ff);
   assign need      = {1'b0, count_ff} + (CW+1)'(extra);

   always_comb begin
      sts.scan_end   = (i_ff == count_ff);
      sts.p_hit      = p_hit;
      sts.req_find   = (kind_ff == sdif_pkg::REQ_FIND);
      sts.zero_key   = ({req_ff.index, req_ff.sub, req_ff.flags} == 32'd0);
      sts.full       = need > (CW+1)'(sdif_pkg::TABLE_DEPTH);
      sts.sub_zero   = (req_ff.sub == 8'd0);
      sts.match      = match_ff;
      sts.has_cnt    = hascnt_ff;
      sts.shift_done = (j_ff == pos_ff);
      sts.phase_cnt  = phase_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   // memory port selection
   always_comb begin
      re    = cmd.scan_rd || cmd.shift_rd || cmd.cnt_rd || cmd.out_rd;
      raddr = i_ff[AW-1:0];
      if (cmd.shift_rd)    raddr = j_dec[AW-1:0];
      else if (cmd.cnt_rd) raddr = c_ff[AW-1:0];
      else if (cmd.out_rd) raddr = p_ff[AW-1:0];

      we    = cmd.upd_wr || cmd.shift_wr || cmd.ins_wr || (cmd.cnt_wr && cnt_lower);
      waddr = p_ff[AW-1:0];
      wdata = req_ff;
      if (cmd.shift_wr) begin
         waddr = j_ff[AW-1:0];
         wdata = rd_q_ff;
      end else if (cmd.ins_wr) begin
         waddr = pos_ff[AW-1:0];
         if (phase_ff) begin
            wdata.index = req_ff.index;
            wdata.sub   = 8'd0;
            wdata.flags = cfg_flags_ff;
            wdata.etype = cfg_type_ff;
            wdata.data  = 32'(req_ff.sub);
         end
      end else if (cmd.cnt_wr) begin
         waddr      = c_ff[AW-1:0];
         wdata      = rd_q_ff;
         wdata.data = 32'(req_ff.sub);
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_q_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff  <= req_entry;
         kind_ff <= req_kind;
      end
      if (cmd.accept) i_ff <= '0;
      else if (cmd.scan_chk) i_ff <= i_ff + CW'(1);
      if (cmd.scan_chk && c_hit) begin
         c_ff      <= i_ff;
         hascnt_ff <= (dev_rd == cdev);
      end else if (cmd.scan_end_set && !cdone_ff) begin
         c_ff      <= count_ff;
         hascnt_ff <= 1'b0;
      end
      if (cmd.scan_chk && p_hit) begin
         p_ff     <= i_ff;
         match_ff <= (dev_rd == tdev);
      end else if (cmd.scan_end_set && !pdone_ff) begin
         p_ff     <= count_ff;
         match_ff <= 1'b0;
      end else if (cmd.shift_start_cnt) begin
         p_ff <= p_ff + CW'(1);
      end
      if (cmd.shift_start_main) begin
         pos_ff   <= p_ff;
         j_ff     <= count_ff;
         phase_ff <= 1'b0;
      end else if (cmd.shift_start_cnt) begin
         pos_ff   <= c_ff;
         j_ff     <= count_ff;
         phase_ff <= 1'b1;
      end else if (cmd.shift_wr) begin
         j_ff <= j_dec;
      end
      if (cmd.set_status) status_ff <= cmd.status_code;
      if (cmd.out_load) begin
         rsp_status_ff <= status_ff;
         rsp_slot_ff   <= have_ff ? sdif_pkg::SLOT_W'(p_ff) : '0;
         rsp_flags_ff  <= have_ff ? rd_q_ff.flags : 8'd0;
         rsp_type_ff   <= have_ff ? rd_q_ff.etype : 8'd0;
         rsp_data_ff   <= have_ff ? rd_q_ff.data  : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pdone_ff     <= 1'b0;
         cdone_ff     <= 1'b0;
         have_ff      <= 1'b0;
         count_ff     <= '0;
         cfg_type_ff  <= 8'd0;
         cfg_flags_ff <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            pdone_ff <= 1'b0;
            cdone_ff <= 1'b0;
         end else if (cmd.scan_chk) begin
            if (c_hit) cdone_ff <= 1'b1;
            if (p_hit) pdone_ff <= 1'b1;
         end
         if (cmd.set_status) have_ff <= cmd.set_have;
         if (cmd.ins_wr) count_ff <= count_ff + CW'(1);
         if (csr_valid) begin
            if (csr_index == sdif_pkg::CSR_COUNT_TYPE) cfg_type_ff  <= csr_data;
            else                                       cfg_flags_ff <= csr_data;
         end
         if (cmd.out_load)  rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_flags  = rsp_flags_ff;
   assign rsp_type   = rsp_type_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(sdif_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");
   a_slot_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && have_ff |-> p_ff < count_ff)
      else $error("reported slot not a live entry");
   a_shift_order: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> j_ff > pos_ff)
      else $error("shift below insertion point");
   a_ins_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_wr |-> count_ff < CW'(sdif_pkg::TABLE_DEPTH))
      else $error("insert into full table");
`endif

endmodule
`default_nettype wire

// ----- design/sorted_dictionary_insert_find_core.sv -----
// Each item scans the sorted table up to the key; an insert then moves the entries from its slot
// upward, with up to two shifts when a count entry is created.
// One item at a time: a new request is taken only in the idle state, after the last result is loaded.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous): table empty, config registers zero, no result pending.
`default_nettype none
module sorted_dictionary_insert_find_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [71:0]  req_tdata,   // entry_index, entry_sub, entry_flags, entry_type, entry_data
   input  wire [0:0]   req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,   // slot, found_flags, found_type, found_data, zero pad
   output logic [2:0]  rsp_tuser,   // status
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire [7:0]   csr_data
);

   sdif_pkg::dp_cmd_type cmd;
   sdif_pkg::dp_sts_type sts;
   sdif_pkg::entry_type  req_entry;
   logic [6:0]           slot;
   logic [7:0]           fl, ty;
   logic [31:0]          da;

   assign req_entry.index = req_tdata[15:0];
   assign req_entry.sub   = req_tdata[23:16];
   assign req_entry.flags = req_tdata[31:24];
   assign req_entry.etype = req_tdata[39:32];
   assign req_entry.data  = req_tdata[71:40];
   assign csr_ready       = 1'b1;
   assign rsp_tdata       = {1'b0, da, ty, fl, slot};

   sdif_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sdif_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_kind   (req_tuser[0]),
      .req_entry  (req_entry),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_slot   (slot),
      .rsp_flags  (fl),
      .rsp_type   (ty),
      .rsp_data   (da)
   );

endmodule
`default_nettype wire

// ----- tb/sdif_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module sdif_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire [71:0]  req_tdata,
   input  wire [0:0]   req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire [55:0]  rsp_tdata,
   input  wire [2:0]   rsp_tuser,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire         csr_index,
   input  wire [7:0]   csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      sdif_pkg::status_type status;
      logic [6:0]  slot;
      logic [7:0]  flags;
      logic [7:0]  etype;
      logic [31:0] data;
   } lookup_rsp_type;

   // model of the table
   logic [31:0] key_mem [sdif_pkg::TABLE_DEPTH];
   logic [39:0] val_mem [sdif_pkg::TABLE_DEPTH];
   int          n_entries;
   logic [7:0]  cnt_type, cnt_flags;

   lookup_rsp_type rsp_queue[$];

   function automatic int first_not_below(logic [23:0] dev);
      int i;
      i = 0;
      while (i < n_entries && key_mem[i][31:8] < dev) i++;
      return i;
   endfunction

   function automatic void shift_in(int pos, logic [31:0] key, logic [39:0] val);
      for (int j = n_entries; j > pos; j--) begin
         key_mem[j] = key_mem[j-1];
         val_mem[j] = val_mem[j-1];
      end
      key_mem[pos] = key;
      val_mem[pos] = val;
      n_entries++;
   endfunction

   function automatic lookup_rsp_type dictionary_step(logic kind, logic [71:0] d);
      logic [15:0] idx;
      logic [7:0]  sub, fl, ty;
      logic [31:0] da;
      logic [31:0] key;
      int          p, c, extra;
      logic        match, has_cnt, have;
      lookup_rsp_type r;
      idx = d[15:0];
      sub = d[23:16];
      fl  = d[31:24];
      ty  = d[39:32];
      da  = d[71:40];
      key = {idx, sub, fl};
      p = first_not_below(key[31:8]);
      match = (p < n_entries) && (key_mem[p][31:8] == key[31:8]);
      have = 1'b0;
      r = '0;
      if (kind == sdif_pkg::REQ_FIND) begin
         r.status = match ? sdif_pkg::ST_FOUND : sdif_pkg::ST_NOT_FOUND;
         have = match;
      end else if (key == 32'd0) begin
         r.status = sdif_pkg::ST_ZERO_KEY;
      end else begin
         c = 0;
         has_cnt = 1'b0;
         extra = match ? 0 : 1;
         if (sub != 8'd0) begin
            c = first_not_below({idx, 8'd0});
            has_cnt = (c < n_entries) && (key_mem[c][31:8] == {idx, 8'd0});
            if (!has_cnt) extra++;
         end
         if (n_entries + extra > sdif_pkg::TABLE_DEPTH) begin
            r.status = sdif_pkg::ST_FULL;
         end else begin
            if (match) begin
               key_mem[p] = key;
               val_mem[p] = {ty, da};
               r.status = sdif_pkg::ST_UPDATED;
            end else begin
               shift_in(p, key, {ty, da});
               r.status = sdif_pkg::ST_INSERTED;
            end
            if (sub != 8'd0) begin
               if (has_cnt) begin
                  if (val_mem[c][31:0] < {24'd0, sub})
                     val_mem[c][31:0] = {24'd0, sub};
               end else begin
                  shift_in(c, {idx, 8'd0, cnt_flags}, {cnt_type, 24'd0, sub});
                  p++;
               end
            end
            have = 1'b1;
         end
      end
      if (have && p < n_entries) begin
         r.slot  = p[6:0];
         r.flags = key_mem[p][7:0];
         r.etype = val_mem[p][39:32];
         r.data  = val_mem[p][31:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_rsp_type want, got;
      if (reset) begin
         n_entries  = 0;
         cnt_type   = '0;
         cnt_flags  = '0;
         fail_count = 0;
         pending    <= 0;
         rsp_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == sdif_pkg::CSR_COUNT_TYPE) cnt_type = csr_data;
            else cnt_flags = csr_data;
         end
         if (req_tvalid && req_tready)
            rsp_queue.push_back(dictionary_step(req_tuser[0], req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.status = sdif_pkg::status_type'(rsp_tuser);
            got.slot   = rsp_tdata[6:0];
            got.flags  = rsp_tdata[14:7];
            got.etype  = rsp_tdata[22:15];
            got.data   = rsp_tdata[54:23];
            if (rsp_queue.size() == 0) begin
               $display("%0t: unexpected item status=%0d slot=%0d", $time,
                        got.status, got.slot);
               fail_count = fail_count + 1;
            end else begin
               want = rsp_queue.pop_front();
               if (got.status !== want.status || got.slot !== want.slot ||
                   got.flags !== want.flags || got.etype !== want.etype ||
                   got.data !== want.data) begin
                  $display("%0t: mismatch exp st=%0d slot=%0d fl=%h ty=%h d=%h",
                           $time, want.status, want.slot, want.flags, want.etype,
                           want.data);
                  $display("%0t:          got st=%0d slot=%0d fl=%h ty=%h d=%h",
                           $time, got.status, got.slot, got.flags, got.etype,
                           got.data);
                  fail_count = fail_count + 1;
               end
               if (rsp_tdata[55] !== 1'b0) begin
                  $display("%0t: pad bit exp 0 got %b", $time, rsp_tdata[55]);
                  fail_count = fail_count + 1;
               end
            end
         end
         pending <= rsp_queue.size();
      end
   end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int LONG_HOLD      = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = '0;
   int          fail_count, pending;
   logic        hold_off = 1'b0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   logic [15:0] index_pool [6];

   always #2 clock = ~clock;

   sorted_dictionary_insert_find_core dut (.*);

   sdif_checker checker_i (.*);

   // receiver: own stall pattern, plus one long hold-off on request
   always @(posedge clock) begin
      int mode_left, mode, hold_left;
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left = 0;
         hold_left = 0;
      end else begin
         if (hold_off && hold_left == 0) hold_left = LONG_HOLD;
         if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) hold_off <= 1'b0;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(16, 128);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_dictionary_insert_find_core verification failed");
            $finish;
         end
      end
   end

   task automatic send_request(logic kind, logic [15:0] idx, logic [7:0] sub,
                               logic [7:0] fl, logic [7:0] ty, logic [31:0] da);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {da, ty, fl, sub, idx};
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic which, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic random_request;
      logic        kind;
      logic [15:0] idx;
      logic [7:0]  sub;
      int          pick;
      kind = ($urandom_range(0, 9) < 4) ? sdif_pkg::REQ_FIND : sdif_pkg::REQ_ADD;
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         send_request(sdif_pkg::REQ_ADD, 16'd0, 8'd0, 8'd0, 8'($urandom), $urandom);
      end else begin
         pick = $urandom_range(0, 9);
         idx = (pick < 6) ? index_pool[$urandom_range(0, 5)] :
               (pick == 6) ? 16'd0 : 16'($urandom);
         pick = $urandom_range(0, 9);
         sub = (pick < 4) ? 8'd0 : (pick < 8) ? 8'($urandom_range(1, 15)) : 8'($urandom);
         send_request(kind, idx, sub, 8'($urandom), 8'($urandom), $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < 6; i++) index_pool[i] = 16'($urandom);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, zero key, all-zero created count entry, extremes
      send_request(sdif_pkg::REQ_FIND, 16'd0, 8'd0, 8'h77, 8'd0, 32'd0);
      send_request(sdif_pkg::REQ_ADD, 16'd0, 8'd0, 8'd0, 8'h11, 32'h1);
      send_request(sdif_pkg::REQ_ADD, 16'd0, 8'd3, 8'd0, 8'h22, 32'h2);
      send_request(sdif_pkg::REQ_FIND, 16'd0, 8'd0, 8'd0, 8'd0, 32'd0);
      send_request(sdif_pkg::REQ_ADD, 16'd0, 8'd0, 8'h01, 8'h33, 32'h3);
      send_request(sdif_pkg::REQ_ADD, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_request(sdif_pkg::REQ_FIND, 16'hFFFF, 8'd0, 8'd0, 8'd0, 32'd0);
      send_request(sdif_pkg::REQ_ADD, 16'hFFFF, 8'h10, 8'h00, 8'h00, 32'h0);
      send_request(sdif_pkg::REQ_ADD, 16'h1234, 8'd0, 8'h0F, 8'h44, 32'd0);
      send_request(sdif_pkg::REQ_ADD, 16'h1234, 8'd5, 8'hF0, 8'h55, 32'hA5A5_5A5A);
      send_request(sdif_pkg::REQ_ADD, 16'h1234, 8'd5, 8'h0F, 8'h66, 32'h5A5A_A5A5);
      send_request(sdif_pkg::REQ_ADD, 16'h1234, 8'd2, 8'h01, 8'h77, 32'h1);
      send_request(sdif_pkg::REQ_FIND, 16'h1234, 8'd0, 8'd0, 8'd0, 32'd0);
      send_request(sdif_pkg::REQ_FIND, 16'h1234, 8'd5, 8'd0, 8'd0, 32'd0);
      send_request(sdif_pkg::REQ_FIND, 16'h1234, 8'd6, 8'd0, 8'd0, 32'd0);
      send_request(sdif_pkg::REQ_FIND, 16'h8000, 8'h80, 8'd0, 8'd0, 32'd0);
      send_request(sdif_pkg::REQ_FIND, 16'hFFFF, 8'hFF, 8'd0, 8'd0, 32'd0);
      drain();

      write_csr(sdif_pkg::CSR_COUNT_TYPE, 8'hFF);
      write_csr(sdif_pkg::CSR_COUNT_FLAGS, 8'hFF);
      csr_valid <= 1'b0;
      hold_off <= 1'b1;   // receiver stalls while the sender keeps offering
      repeat (150) random_request();
      drain();

      write_csr(sdif_pkg::CSR_COUNT_TYPE, 8'h00);
      write_csr(sdif_pkg::CSR_COUNT_FLAGS, 8'h00);
      csr_valid <= 1'b0;
      repeat (150) random_request();
      drain();

      write_csr(sdif_pkg::CSR_COUNT_TYPE, 8'($urandom));
      write_csr(sdif_pkg::CSR_COUNT_FLAGS, 8'($urandom));
      csr_valid <= 1'b0;
      repeat (150) random_request();
      drain();

      repeat (50) @(posedge clock);
      if (fail_count == 0)
         $display("sorted_dictionary_insert_find_core verification clean");
      else
         $display("sorted_dictionary_insert_find_core verification failed");
      $finish;
   end

endmodule
`default_nettype wire
